### rtl/mslf_pkg.sv
// ----------------------------------------------------------------------------
// mslf_pkg : shared types and constants for the masked soften luma filter
// Geometry limits, queue entry layout and configuration register codes.
// ----------------------------------------------------------------------------
package mslf_pkg;

  localparam int MaxRadius = 2;
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4095;
  localparam int WinSide   = 2 * MaxRadius + 1;
  localparam int MinSize   = (WinSide > 5) ? WinSide : 5;
  localparam int LsRows    = 2 * MaxRadius;

  localparam int PixW  = 8;
  localparam int CfgW  = 12;
  localparam int RadW  = 2;
  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = 13;
  localparam int SumW  = $clog2(WinSide * WinSide * 256);
  localparam int CntW  = $clog2(WinSide * WinSide + 1);
  localparam int RsumW = $clog2(WinSide * 255 + 1);
  localparam int DivCntW = $clog2(SumW);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegRadius = 2'd2,
    RegThresh = 2'd3
  } cfg_reg_e;

  // clamped geometry seen by both halves
  typedef struct packed {
    logic [CfgW-1:0] w;
    logic [CfgW-1:0] h;
    logic [RadW-1:0] r;
    logic [PixW-1:0] thr;
  } geom_t;

  // one column push from front to back
  typedef struct packed {
    logic [WinSide-1:0][PixW-1:0] col;
    logic                         emit;
    logic                         border;
    logic                         last;
  } qent_t;

endpackage

### rtl/mslf_if.sv
// ----------------------------------------------------------------------------
// mslf_if : request channels of the masked soften luma filter
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface mslf_in_if;
  logic                      valid;
  logic                      ready;
  logic [mslf_pkg::PixW-1:0] luma_in;
  logic                      drain;
  modport source (output valid, luma_in, drain, input ready);
  modport sink   (input valid, luma_in, drain, output ready);
endinterface

interface mslf_out_if;
  logic                      valid;
  logic                      ready;
  logic [mslf_pkg::PixW-1:0] luma_out;
  logic                      frame_end;
  modport source (output valid, luma_out, frame_end, input ready);
  modport sink   (input valid, luma_out, frame_end, output ready);
endinterface

interface mslf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                index;
  logic [mslf_pkg::CfgW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mslf_queue.sv
// ----------------------------------------------------------------------------
// mslf_queue : short column queue between front and back end
// Register-based FIFO with fill count.
// ----------------------------------------------------------------------------
module mslf_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  mslf_pkg::qent_t            data_i,
  input  logic                       pop_i,
  output mslf_pkg::qent_t            data_o,
  output logic                       empty_o,
  output logic [mslf_pkg::QCntW-1:0] count_o
);

  mslf_pkg::qent_t                 mem_q [mslf_pkg::QDepth];
  logic [mslf_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [mslf_pkg::QCntW-1:0]      cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

### rtl/mslf_front.sv
// ----------------------------------------------------------------------------
// mslf_front : request intake, raster counters and line store
// Classifies each request, rotates the line store column and queues it.
// ----------------------------------------------------------------------------
module mslf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mslf_pkg::geom_t            geom_i,
  input  logic                       restart_i,
  mslf_in_if.sink                    pix_in,
  input  logic [mslf_pkg::QCntW-1:0] q_count_i,
  output logic                       push_o,
  output mslf_pkg::qent_t            push_data_o
);

  logic [mslf_pkg::ColW-1:0]   col_q, ox_q;
  logic [mslf_pkg::RowW-1:0]   row_q;
  logic [mslf_pkg::CfgW-1:0]   oy_q;

  logic [mslf_pkg::LsRows-1:0][mslf_pkg::PixW-1:0] ls_q [mslf_pkg::MaxWidth];
  logic [mslf_pkg::LsRows-1:0][mslf_pkg::PixW-1:0] rd_q, wr_data;

  logic                          b_valid_q;
  logic [mslf_pkg::PixW-1:0]     b_pix_q;
  logic [mslf_pkg::ColW-1:0]     b_addr_q;
  logic                          b_emit_q, b_border_q, b_last_q;

  logic accept, ignore, take, in_frame, reached, interior, last, col_wrap;
  logic [mslf_pkg::WinSide-1:0][mslf_pkg::PixW-1:0] col_c;
  int ri;

  assign ri       = int'(geom_i.r);
  assign in_frame = row_q < {1'b0, geom_i.h};
  assign ignore   = pix_in.drain && in_frame;
  assign accept   = pix_in.valid && pix_in.ready;
  assign take     = accept && !ignore;

  // room for the item in stage B plus the new one
  assign pix_in.ready = (32'(q_count_i) + 32'(b_valid_q)) < mslf_pkg::QDepth;

  // output starts once radius lines plus radius pixels have arrived
  assign reached = (row_q > mslf_pkg::RowW'(geom_i.r)) ||
                   ((row_q == mslf_pkg::RowW'(geom_i.r)) &&
                    (col_q >= mslf_pkg::ColW'(geom_i.r)));

  // position of the pixel being output
  assign interior = (oy_q >= mslf_pkg::CfgW'(geom_i.r)) &&
                    (({1'b0, oy_q} + (mslf_pkg::CfgW+1)'(geom_i.r)) < {1'b0, geom_i.h}) &&
                    (ox_q >= mslf_pkg::ColW'(geom_i.r)) &&
                    (({2'b0, ox_q} + (mslf_pkg::CfgW+1)'(geom_i.r)) < {1'b0, geom_i.w});
  assign last     = (oy_q == geom_i.h - 1'b1) &&
                    ({1'b0, ox_q} == geom_i.w - 1'b1);
  assign col_wrap = ({1'b0, col_q} + 1'b1) == geom_i.w;

  // raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (take) begin
      if (reached && last) begin
        col_q <= '0;
        row_q <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
      end else begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
        if (reached) begin
          if ({1'b0, ox_q} == geom_i.w - 1'b1) begin
            ox_q <= '0;
            oy_q <= oy_q + 1'b1;
          end else begin
            ox_q <= ox_q + 1'b1;
          end
        end
      end
    end
  end

  // stage B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= take;
    end
  end

  // stage B payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      b_pix_q    <= in_frame ? pix_in.luma_in : '0;
      b_addr_q   <= col_q;
      b_emit_q   <= reached;
      b_border_q <= !interior;
      b_last_q   <= last;
    end
  end

  // line store: read on intake, write back the rotated column in stage B
  always_ff @(posedge clk_i) begin
    if (take)      rd_q <= ls_q[col_q];
    if (b_valid_q) ls_q[b_addr_q] <= wr_data;
  end

  // assemble the new window column
  always_comb begin
    col_c = '0;
    for (int k = 0; k < mslf_pkg::LsRows; k++) begin
      if (k < 2 * ri) col_c[k] = rd_q[k];
    end
    for (int k = 0; k < mslf_pkg::WinSide; k++) begin
      if (k == 2 * ri) col_c[k] = b_pix_q;
    end
    for (int k = 0; k < mslf_pkg::LsRows; k++) begin
      wr_data[k] = (k < 2 * ri) ? col_c[k+1] : rd_q[k];
    end
  end

  assign push_o             = b_valid_q;
  assign push_data_o.col    = col_c;
  assign push_data_o.emit   = b_emit_q;
  assign push_data_o.border = b_border_q;
  assign push_data_o.last   = b_last_q;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (32'(q_count_i) < mslf_pkg::QDepth))
    else $error("column queue overflow");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < geom_i.w)
    else $error("input column beyond line width");
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && reached && last |=> (ox_q == '0) && (oy_q == '0) && (row_q == '0))
    else $error("frame did not restart after last pixel");
`endif

endmodule

### rtl/mslf_back.sv
// ----------------------------------------------------------------------------
// mslf_back : window, selective sum and divider
// Shifts queued columns into the window and works out each result.
// ----------------------------------------------------------------------------
module mslf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mslf_pkg::geom_t geom_i,
  input  logic            empty_i,
  input  mslf_pkg::qent_t data_i,
  output logic            pop_o,
  mslf_out_if.source      pix_out
);

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SMask = 6'b000010,
    SRow  = 6'b000100,
    SSum  = 6'b001000,
    SDiv  = 6'b010000,
    SOut  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [mslf_pkg::WinSide-1:0][mslf_pkg::WinSide-1:0][mslf_pkg::PixW-1:0] win_q, mv_q;
  logic [mslf_pkg::WinSide-1:0][mslf_pkg::RsumW-1:0] rs_q;
  logic [mslf_pkg::CntW-1:0]    cnt_q;
  logic [mslf_pkg::PixW-1:0]    centre_q, res_q;
  logic [mslf_pkg::SumW-1:0]    num_q, num_d;
  logic [mslf_pkg::CntW-1:0]    rem_q, rem_d;
  logic [mslf_pkg::DivCntW-1:0] div_cnt_q;
  logic                         border_q, last_q;
  logic                         out_valid_q;
  logic [mslf_pkg::PixW-1:0]    out_luma_q;
  logic                         out_end_q;

  logic [mslf_pkg::WinSide-1:0][mslf_pkg::WinSide-1:0] sel;
  logic [mslf_pkg::WinSide-1:0][mslf_pkg::RsumW-1:0] rs_c;
  logic [mslf_pkg::PixW-1:0] centre_c;
  logic [mslf_pkg::SumW-1:0] total_c;
  logic [mslf_pkg::CntW:0]   trial;
  logic                      out_free;
  int ri;

  assign ri       = int'(geom_i.r);
  assign pop_o    = (state_q == SIdle) && !empty_i;
  assign out_free = !out_valid_q || pix_out.ready;
  assign centre_c = win_q[ri][mslf_pkg::WinSide-1-ri];

  // neighbours inside the window and close enough to the centre
  always_comb begin
    for (int y = 0; y < mslf_pkg::WinSide; y++) begin
      for (int x = 0; x < mslf_pkg::WinSide; x++) begin
        sel[y][x] = (y <= 2 * ri) && (x >= mslf_pkg::WinSide - 1 - 2 * ri) &&
                    (((win_q[y][x] > centre_c) ? (win_q[y][x] - centre_c)
                                              : (centre_c - win_q[y][x])) <= geom_i.thr);
      end
    end
  end

  // row sums of the masked window
  always_comb begin
    for (int y = 0; y < mslf_pkg::WinSide; y++) begin
      rs_c[y] = '0;
      for (int x = 0; x < mslf_pkg::WinSide; x++) begin
        rs_c[y] = rs_c[y] + mslf_pkg::RsumW'(mv_q[y][x]);
      end
    end
  end

  // total of row sums plus rounding offset
  always_comb begin
    total_c = mslf_pkg::SumW'(cnt_q >> 1) - 1'b1;
    for (int y = 0; y < mslf_pkg::WinSide; y++) begin
      total_c = total_c + mslf_pkg::SumW'(rs_q[y]);
    end
  end

  // one restoring divide step
  assign trial = {rem_q, num_q[mslf_pkg::SumW-1]};
  always_comb begin
    if (trial >= {1'b0, cnt_q}) begin
      rem_d = mslf_pkg::CntW'(trial - {1'b0, cnt_q});
      num_d = {num_q[mslf_pkg::SumW-2:0], 1'b1};
    end else begin
      rem_d = trial[mslf_pkg::CntW-1:0];
      num_d = {num_q[mslf_pkg::SumW-2:0], 1'b0};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (pop_o && data_i.emit) state_d = SMask;
      SMask: state_d = SRow;
      SRow:  state_d = SSum;
      SSum:  state_d = (border_q || (cnt_q <= 1)) ? SOut : SDiv;
      SDiv:  if (div_cnt_q == '0) state_d = SOut;
      SOut:  if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SOut && out_free) out_valid_q <= 1'b1;
      else if (pix_out.ready)          out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int y = 0; y < mslf_pkg::WinSide; y++) begin
        for (int x = 0; x < mslf_pkg::WinSide - 1; x++) begin
          win_q[y][x] <= win_q[y][x+1];
        end
        win_q[y][mslf_pkg::WinSide-1] <= data_i.col[y];
      end
      border_q <= data_i.border;
      last_q   <= data_i.last;
    end
    if (state_q == SMask) begin
      for (int y = 0; y < mslf_pkg::WinSide; y++) begin
        for (int x = 0; x < mslf_pkg::WinSide; x++) begin
          mv_q[y][x] <= sel[y][x] ? win_q[y][x] : '0;
        end
      end
      cnt_q    <= mslf_pkg::CntW'($countones(sel));
      centre_q <= centre_c;
    end
    if (state_q == SRow) begin
      rs_q <= rs_c;
    end
    if (state_q == SSum) begin
      num_q     <= total_c;
      rem_q     <= '0;
      div_cnt_q <= mslf_pkg::DivCntW'(mslf_pkg::SumW - 1);
      res_q     <= centre_q;
    end
    if (state_q == SDiv) begin
      num_q     <= num_d;
      rem_q     <= rem_d;
      div_cnt_q <= div_cnt_q - 1'b1;
      if (div_cnt_q == '0) res_q <= num_d[mslf_pkg::PixW-1:0];
    end
    if (state_q == SOut && out_free) begin
      out_luma_q <= res_q;
      out_end_q  <= last_q;
    end
  end

  assign pix_out.valid     = out_valid_q;
  assign pix_out.luma_out  = out_luma_q;
  assign pix_out.frame_end = out_end_q;

endmodule

### rtl/masked_soften_luma_filter.sv
// ----------------------------------------------------------------------------
// masked_soften_luma_filter : selective-average soften of a luma stream
// Front end with line store, column queue, back end with window and divider.
// ----------------------------------------------------------------------------
// Output begins once R lines plus R pixels of input have arrived. Each result
// passes stage B, the column queue and the back-end states Mask, Row, Sum, Div
// (13-step bit-serial divider, interior only) and Out; the sequencer pops no
// new column until idle again, and a request without a result only passes idle.
// Reset: registers return to 720, 576, 2, 5, raster counters, queue pointers
// and fill count clear; the line store is not cleared and needs no clearing pass.
module masked_soften_luma_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  mslf_in_if.sink    pix_in,
  mslf_out_if.source pix_out,
  mslf_cfg_if.sink   cfg
);

  logic [mslf_pkg::CfgW-1:0] width_q, height_q;
  logic [mslf_pkg::RadW-1:0] radius_q;
  logic [mslf_pkg::PixW-1:0] thresh_q;
  logic                      cfg_we, restart;
  mslf_pkg::geom_t           geom;
  logic                      push, pop, empty;
  mslf_pkg::qent_t           push_data, pop_data;
  logic [mslf_pkg::QCntW-1:0] q_count;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;
  assign restart   = cfg_we && (cfg.index != mslf_pkg::RegThresh);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd720;
      height_q <= 12'd576;
      radius_q <= 2'd2;
      thresh_q <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg.index)
        mslf_pkg::RegWidth:  width_q  <= cfg.data;
        mslf_pkg::RegHeight: height_q <= cfg.data;
        mslf_pkg::RegRadius: radius_q <= cfg.data[mslf_pkg::RadW-1:0];
        mslf_pkg::RegThresh: thresh_q <= cfg.data[mslf_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // saturate geometry into the supported range
  always_comb begin
    geom.w = width_q;
    if (32'(width_q) < mslf_pkg::MinSize)  geom.w = mslf_pkg::CfgW'(mslf_pkg::MinSize);
    if (32'(width_q) > mslf_pkg::MaxWidth) geom.w = mslf_pkg::CfgW'(mslf_pkg::MaxWidth);
    geom.h = height_q;
    if (32'(height_q) < mslf_pkg::MinSize)   geom.h = mslf_pkg::CfgW'(mslf_pkg::MinSize);
    if (32'(height_q) > mslf_pkg::MaxHeight) geom.h = mslf_pkg::CfgW'(mslf_pkg::MaxHeight);
    geom.r = radius_q;
    if (radius_q == '0) geom.r = mslf_pkg::RadW'(1);
    if (32'(radius_q) > mslf_pkg::MaxRadius) geom.r = mslf_pkg::RadW'(mslf_pkg::MaxRadius);
    geom.thr = thresh_q;
  end

  mslf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .restart_i   (restart),
    .pix_in      (pix_in),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mslf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty),
    .count_o (q_count)
  );

  mslf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .empty_i (empty),
    .data_i  (pop_data),
    .pop_o   (pop),
    .pix_out (pix_out)
  );

endmodule

### verif/mslf_tb_if.sv
// ----------------------------------------------------------------------------
// mslf_tb_if : testbench-side note on channel interfaces
// The channel interfaces come from the RTL file set; nothing is redefined here.
// ----------------------------------------------------------------------------
package mslf_tb_pkg;

  // idle profiles for sender and receiver, in percent
  typedef struct {
    int unsigned send_idle;
    int unsigned recv_idle;
  } idle_prof_t;

endpackage

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the masked soften luma filter
// Drives small frames through the filter under several geometries and
// thresholds, predicts every output pixel in a behavioural window model and
// compares each output request field by field, with random idling both sides.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [mslf_pkg::PixW-1:0] luma;
    logic                      fend;
  } pix_res_t;

  // directed stimulus row: optional typed-in expectation
  typedef struct {
    logic [mslf_pkg::PixW-1:0] luma;
    logic                      drain;
    logic                      has_exp;
    logic [mslf_pkg::PixW-1:0] exp_luma;
    logic                      exp_fend;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mslf_in_if  pix_in ();
  mslf_out_if pix_out ();
  mslf_cfg_if cfg ();

  masked_soften_luma_filter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_in.sink),
    .pix_out (pix_out.source),
    .cfg     (cfg.sink)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  int unsigned soft_w, soft_h, soft_r, soft_thr;
  byte unsigned line_mem [mslf_pkg::LsRows][mslf_pkg::MaxWidth];
  byte unsigned win [mslf_pkg::WinSide][mslf_pkg::WinSide];
  int unsigned in_col, in_row, out_cnt;

  pix_res_t    expected_pix[$];
  pix_res_t    typed_pix[$];
  logic        typed_flag[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned recv_idle;
  bit          final_check;

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_cnt = 0;
  endfunction

  function automatic void soften_reg_write(mslf_pkg::cfg_reg_e idx, int unsigned val);
    case (idx)
      mslf_pkg::RegWidth: begin
        soft_w = val & 12'hFFF;
        restart_frame();
      end
      mslf_pkg::RegHeight: begin
        soft_h = val & 12'hFFF;
        restart_frame();
      end
      mslf_pkg::RegRadius: begin
        soft_r = val & 2'h3;
        restart_frame();
      end
      default: soft_thr = val & 8'hFF;
    endcase
  endfunction

  // advance the window model by one request; returns 1 with a result
  function automatic bit soften_step(logic [mslf_pkg::PixW-1:0] luma, logic drain,
                                     output pix_res_t res);
    int unsigned r, w, h, total, lag, side, x, pos, p, oy, ox;
    int unsigned sum, cnt, v, d, cen, outv;
    byte unsigned column [mslf_pkg::WinSide];
    r = clampv(soft_r, 1, mslf_pkg::MaxRadius);
    w = clampv(soft_w, mslf_pkg::MinSize, mslf_pkg::MaxWidth);
    h = clampv(soft_h, mslf_pkg::MinSize, mslf_pkg::MaxHeight);
    total = w * h;
    lag = r * w + r;
    side = 2 * r + 1;
    x = in_col % w;
    pos = in_row * w + x;
    if (drain && pos < total) return 0;
    column[2*r] = (pos < total) ? luma : 0;
    for (int k = 0; k < 2 * r; k++) column[k] = line_mem[k][x];
    for (int k = 0; k < 2 * r; k++) line_mem[k][x] = column[k+1];
    for (int k = 0; k < side; k++) begin
      for (int c = 0; c + 1 < side; c++) win[k][c] = win[k][c+1];
      win[k][side-1] = column[k];
    end
    in_col = x + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < lag) return 0;
    p = out_cnt;
    oy = p / w;
    ox = p % w;
    cen = win[r][r];
    outv = cen;
    if (oy >= r && oy + r < h && ox >= r && ox + r < w) begin
      sum = 0;
      cnt = 0;
      for (int k = 0; k < side; k++)
        for (int c = 0; c < side; c++) begin
          v = win[k][c];
          d = (v > cen) ? v - cen : cen - v;
          if (d <= soft_thr) begin
            sum += v;
            cnt++;
          end
        end
      if (cnt > 1) outv = (sum + (cnt >> 1) - 1) / cnt;
    end
    res.luma = outv[mslf_pkg::PixW-1:0];
    res.fend = (p + 1 >= total);
    out_cnt = p + 1;
    if (res.fend) restart_frame();
    return 1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
  endtask

  // output side: random stall, compare with oldest expectation
  always @(posedge clk_i) begin
    pix_res_t e;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      results_seen++;
      if (expected_pix.size() == 0) begin
        report_mismatch("unexpected result", 32'(pix_out.luma_out), 0);
      end else begin
        e = expected_pix.pop_front();
        if (pix_out.luma_out !== e.luma)
          report_mismatch("luma_out", 32'(pix_out.luma_out), 32'(e.luma));
        if (pix_out.frame_end !== e.fend)
          report_mismatch("frame_end", 32'(pix_out.frame_end), 32'(e.fend));
        if (typed_flag.size() != 0) begin
          if (typed_flag.pop_front()) begin
            e = typed_pix.pop_front();
            if (pix_out.luma_out !== e.luma)
              report_mismatch("table luma", 32'(pix_out.luma_out), 32'(e.luma));
            if (pix_out.frame_end !== e.fend)
              report_mismatch("table frame_end", 32'(pix_out.frame_end), 32'(e.fend));
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    pix_out.ready <= final_check ? 1'b1 : ($urandom_range(99) >= recv_idle);
  end

  // one pixel request, with sender idling; valid stays high after the
  // request until the next idle cycle or wait_empty drops it
  task automatic send_pix(logic [mslf_pkg::PixW-1:0] luma, logic drain,
                          int unsigned idle_pct, bit has_exp = 0, pix_res_t typed = '0);
    pix_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.luma_in <= luma;
    pix_in.drain <= drain;
    do @(posedge clk_i); while (!pix_in.ready);
    if (soften_step(luma, drain, res)) begin
      expected_pix.push_back(res);
      typed_flag.push_back(has_exp);
      if (has_exp) typed_pix.push_back(typed);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_empty();
    pix_in.valid <= 1'b0;
    while (expected_pix.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(mslf_pkg::cfg_reg_e idx, int unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val[mslf_pkg::CfgW-1:0];
    do @(posedge clk_i); while (!cfg.ready);
    soften_reg_write(idx, val);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_geom(int unsigned w, int unsigned h, int unsigned r, int unsigned thr);
    wait_empty();
    write_reg(mslf_pkg::RegWidth, w);
    write_reg(mslf_pkg::RegHeight, h);
    write_reg(mslf_pkg::RegRadius, r);
    write_reg(mslf_pkg::RegThresh, thr);
  endtask

  // one frame of mostly well-formed content with occasional drains
  task automatic random_frame(int unsigned idle_pct);
    int unsigned base, w, h;
    base = $urandom_range(255);
    w = clampv(soft_w, mslf_pkg::MinSize, mslf_pkg::MaxWidth);
    h = clampv(soft_h, mslf_pkg::MinSize, mslf_pkg::MaxHeight);
    while (in_row * w + in_col < w * h) begin
      if ($urandom_range(19) == 0)
        send_pix(8'($urandom_range(255)), 1'b1, idle_pct);
      else if ($urandom_range(3) == 0)
        send_pix(8'($urandom_range(255)), 1'b0, idle_pct);
      else
        send_pix(8'(clampv(base + $urandom_range(20) - 10, 0, 255)), 1'b0, idle_pct);
    end
    // tail: mix drains and pixels until the frame end result appears
    while (out_cnt != 0)
      send_pix(8'($urandom_range(255)), 1'($urandom_range(1)), idle_pct);
  endtask

  dir_row_t dir_tab[$];

  initial begin
    mslf_tb_pkg::idle_prof_t prof [3];
    dir_row_t row;
    pix_res_t tr;
    int unsigned thr_set [4];
    prof[0] = '{20, 60};
    prof[1] = '{60, 20};
    prof[2] = '{0, 0};
    thr_set = '{0, 255, 5, 30};
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    final_check = 0;
    recv_idle = 60;
    pix_in.valid = 1'b0;
    pix_in.luma_in = '0;
    pix_in.drain = 1'b0;
    pix_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = mslf_pkg::RegWidth;
    cfg.data = '0;
    soft_w = 720;
    soft_h = 576;
    soft_r = 2;
    soft_thr = 5;
    restart_frame();
    foreach (win[k, c]) win[k][c] = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: 5x5 frame, radius 2, threshold 0: only the centre is interior
    // and passes through; all border pixels copy; a drain mid-frame is ignored,
    // so 26 rows carry the 25 pixels
    write_reg(mslf_pkg::RegWidth, 5);
    write_reg(mslf_pkg::RegHeight, 5);
    write_reg(mslf_pkg::RegRadius, 2);
    write_reg(mslf_pkg::RegThresh, 0);
    for (int i = 0; i < 26; i++) begin
      row.luma = (i % 2) ? 8'hFF : 8'h00;
      row.drain = (i == 3);
      // pixel 0 (value 0) leaves as a border copy once 12 more pixels are in
      row.has_exp = (i == 13);
      row.exp_luma = 8'h00;
      row.exp_fend = 1'b0;
      dir_tab.push_back(row);
    end
    // tail drains: the last corner pixel (0xFF) closes the frame
    row.drain = 1'b1;
    row.luma = 8'h00;
    for (int i = 0; i < 13; i++) begin
      row.has_exp = (i == 11);
      row.exp_luma = 8'hFF;
      row.exp_fend = 1'b1;
      dir_tab.push_back(row);
    end
    foreach (dir_tab[i]) begin
      tr.luma = dir_tab[i].exp_luma;
      tr.fend = dir_tab[i].exp_fend;
      send_pix(dir_tab[i].luma, dir_tab[i].drain, 0, dir_tab[i].has_exp, tr);
    end
    while (out_cnt != 0) send_pix(8'hFF, 1'b1, 0);
    // out-of-range registers: width 0 saturates, radius 0 acts as 1; height 4095 is in range
    set_geom(0, 4095, 0, 255);
    write_reg(mslf_pkg::RegHeight, 5);
    random_frame(0);

    // random phases across idling profiles and settings
    for (int ph = 0; ph < 3; ph++) begin
      recv_idle = prof[ph].recv_idle;
      for (int f = 0; items_sent < 300 * (ph + 1); f++) begin
        set_geom($urandom_range(5, 12), $urandom_range(5, 9), $urandom_range(1, 2),
                 thr_set[f % 4]);
        random_frame(prof[ph].send_idle);
        // pressure: sender holds until the pipeline is empty
        wait_empty();
      end
    end

    final_check = 1;
    wait_empty();
    repeat (100) @(negedge clk_i);
    $display("covered %0d requests and %0d results over several geometries and thresholds",
             items_sent, results_seen);
    if (mismatches == 0 && expected_pix.size() == 0) begin
      $display("[masked_soften_luma_filter] OK");
    end else begin
      $display("[masked_soften_luma_filter] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("[masked_soften_luma_filter] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/mslf_pkg.sv
rtl/mslf_if.sv
rtl/mslf_queue.sv
rtl/mslf_front.sv
rtl/mslf_back.sv
rtl/masked_soften_luma_filter.sv
verif/mslf_tb_if.sv
verif/testbench.sv
